/* rtl/tgac_pkg.sv */
`default_nettype none

package tgac_pkg;

    // Defaults for the top-level parameters
    localparam int NODE_COUNT_DEF  = 16;
    localparam int RIGHTS_BITS_DEF = 8;

    // Fixed widths of the item fields
    localparam int NODE_FIELD_W   = 4;
    localparam int RIGHTS_FIELD_W = 8;

    // Rights bit positions
    localparam int TAKE_BIT  = 0;
    localparam int GRANT_BIT = 1;

    // Which matrix row an access targets
    typedef enum logic [1:0] {
        ROW_A,
        ROW_B,
        ROW_PICK
    } row_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     rd_en;
        row_sel_t rd_sel;
        logic     wr_en;
        row_sel_t wr_sel;
        logic     hold_holders;
        logic     reach_init;
        logic     reach_step;
        logic     out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_query;
        logic a_ok;
        logic b_ok;
        logic reach_more;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/tgac_ram.sv */
`default_nettype none

module tgac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/tgac_ctrl.sv */
`default_nettype none

module tgac_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire tgac_pkg::dp_stat_t stat,
    output tgac_pkg::dp_cmd_t       cmd
);

    import tgac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_WR_A,
        S_INS_RD_B,
        S_INS_WR_B,
        S_Q_HOLD,
        S_REACH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.rd_sel       = ROW_A;
        cmd.wr_sel       = ROW_A;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_query)
                begin
                    cmd.rd_en  = stat.b_ok;
                    cmd.rd_sel = ROW_B;
                    state_next = S_Q_HOLD;
                end
                else if (stat.a_ok && stat.b_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ROW_A;
                    state_next = S_INS_WR_A;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_WR_A:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ROW_A;
                state_next = S_INS_RD_B;
            end
            S_INS_RD_B:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ROW_B;
                state_next = S_INS_WR_B;
            end
            S_INS_WR_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ROW_B;
                state_next = S_IDLE;
            end
            S_Q_HOLD:
            begin
                cmd.hold_holders = 1'b1;
                cmd.reach_init   = 1'b1;
                state_next       = S_REACH;
            end
            S_REACH:
            begin
                // expand one node per cycle until no unexpanded node is left
                cmd.reach_step = 1'b1;
                cmd.rd_en      = stat.reach_more;
                cmd.rd_sel     = ROW_PICK;
                if (!stat.reach_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* rtl/tgac_dp.sv */
`default_nettype none

module tgac_dp #(
    parameter int NODE_COUNT  = tgac_pkg::NODE_COUNT_DEF,
    parameter int RIGHTS_BITS = tgac_pkg::RIGHTS_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tgac_pkg::dp_cmd_t                   cmd,
    output tgac_pkg::dp_stat_t                       stat,
    input  wire logic                                req_type,
    input  wire logic [tgac_pkg::NODE_FIELD_W-1:0]   node_a,
    input  wire logic [tgac_pkg::NODE_FIELD_W-1:0]   node_b,
    input  wire logic [tgac_pkg::RIGHTS_FIELD_W-1:0] rights_mask,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic                                     granted,
    output logic                                     holder_found
);

    import tgac_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int RW    = (RIGHTS_BITS < RIGHTS_FIELD_W) ? RIGHTS_BITS : RIGHTS_FIELD_W;
    localparam int ROW_W = NODE_COUNT * RW;
    localparam logic [RW-1:0] TG_MASK = RW'((1 << TAKE_BIT) | (1 << GRANT_BIT));

    // Item registers
    logic          is_query_reg;
    logic          a_ok_reg;
    logic          b_ok_reg;
    logic [NW-1:0] a_idx_reg;
    logic [NW-1:0] b_idx_reg;
    logic [RW-1:0] want_reg;

    // Row store and per-row valid bits
    logic [NODE_COUNT-1:0] row_valid_reg;
    logic                  rd_valid_reg;
    logic [ROW_W-1:0]      ram_rd_data;
    logic [ROW_W-1:0]      row_data;
    logic [ROW_W-1:0]      row_mod;
    logic [NW-1:0]         ram_rd_addr;
    logic [NW-1:0]         ram_wr_addr;
    logic [NW-1:0]         wr_col;

    // Search state
    logic [NODE_COUNT-1:0] reach_reg;
    logic [NODE_COUNT-1:0] exp_reg;
    logic                  pend_reg;
    logic [NODE_COUNT-1:0] holders_reg;
    logic [NODE_COUNT-1:0] tg_adj;
    logic [NODE_COUNT-1:0] holder_vec;
    logic [NODE_COUNT-1:0] reach_cur;
    logic [NODE_COUNT-1:0] cand;
    logic [NW-1:0]         pick;

    // Result register
    logic rsp_valid_reg;
    logic granted_reg;
    logic holder_found_reg;

    tgac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_rows (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (row_mod),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // A row never written reads as all zero
    assign row_data = rd_valid_reg ? ram_rd_data : '0;

    // Read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            ROW_A:    ram_rd_addr = a_idx_reg;
            ROW_B:    ram_rd_addr = b_idx_reg;
            ROW_PICK: ram_rd_addr = pick;
            default:  ram_rd_addr = a_idx_reg;
        endcase
    end

    // Row update for an insert: row a gets column b, row b gets column a
    assign ram_wr_addr = (cmd.wr_sel == ROW_A) ? a_idx_reg : b_idx_reg;
    assign wr_col      = (cmd.wr_sel == ROW_A) ? b_idx_reg : a_idx_reg;

    always_comb
    begin
        row_mod = row_data;
        row_mod[wr_col*RW +: RW] = want_reg;
    end

    // Per-entry decode of the row just read
    always_comb
    begin
        logic [RW-1:0] ent;
        for (int v = 0; v < NODE_COUNT; v++)
        begin
            ent           = row_data[v*RW +: RW];
            tg_adj[v]     = |(ent & TG_MASK);
            holder_vec[v] = (ent != '0) && ((ent & want_reg) == want_reg);
        end
    end

    // Merge the pending row, then pick the lowest unexpanded reached node
    assign reach_cur = reach_reg | (pend_reg ? tg_adj : '0);
    assign cand      = reach_cur & ~exp_reg;

    always_comb
    begin
        pick = '0;
        for (int i = NODE_COUNT - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick = NW'(i);
            end
        end
    end

    assign stat.is_query   = is_query_reg;
    assign stat.a_ok       = a_ok_reg;
    assign stat.b_ok       = b_ok_reg;
    assign stat.reach_more = |cand;
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    // Item capture, holder set and result values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_query_reg <= req_type;
            a_ok_reg     <= (32'(node_a) < NODE_COUNT);
            b_ok_reg     <= (32'(node_b) < NODE_COUNT);
            a_idx_reg    <= NW'(node_a);
            b_idx_reg    <= NW'(node_b);
            want_reg     <= rights_mask[RW-1:0];
        end
        if (cmd.hold_holders)
        begin
            holders_reg <= b_ok_reg ? holder_vec : '0;
        end
        if (cmd.out_load)
        begin
            granted_reg      <= |(holders_reg & reach_reg);
            holder_found_reg <= |holders_reg;
        end
    end

    // Valid bits, search state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            reach_reg     <= '0;
            exp_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[ram_rd_addr];
            end
            if (cmd.wr_en)
            begin
                row_valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (cmd.reach_init)
            begin
                reach_reg <= a_ok_reg ? (NODE_COUNT'(1) << a_idx_reg) : '0;
                exp_reg   <= '0;
                pend_reg  <= 1'b0;
            end
            else if (cmd.reach_step)
            begin
                reach_reg <= reach_cur;
                if (|cand)
                begin
                    exp_reg  <= exp_reg | (NODE_COUNT'(1) << pick);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted      = granted_reg;
    assign holder_found = holder_found_reg;

endmodule

`default_nettype wire

/* rtl/take_grant_access_check.sv */
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// request  | req_valid, req_stall | req_type, node_a, node_b, rights_mask
// response | rsp_valid, rsp_stall | granted, holder_found
//
// One item at a time. An insert does a read-modify-write of two rows.
// A query searches the nodes reachable from x (at most NODE_COUNT): the search
// reads one matrix row per cycle from the row RAM.
// Reset clears the per-row valid bits at once; there is no clearing pass.
// A finished result waits in the output register while rsp_stall is high.

module take_grant_access_check #(
    parameter int NODE_COUNT  = tgac_pkg::NODE_COUNT_DEF,
    parameter int RIGHTS_BITS = tgac_pkg::RIGHTS_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic                                req_type,
    input  wire logic [tgac_pkg::NODE_FIELD_W-1:0]   node_a,
    input  wire logic [tgac_pkg::NODE_FIELD_W-1:0]   node_b,
    input  wire logic [tgac_pkg::RIGHTS_FIELD_W-1:0] rights_mask,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic                                     granted,
    output logic                                     holder_found
);

    import tgac_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tgac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgac_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .RIGHTS_BITS (RIGHTS_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .node_a       (node_a),
        .node_b       (node_b),
        .rights_mask  (rights_mask),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .holder_found (holder_found)
    );

endmodule

`default_nettype wire

/* tb/sv/take_grant_access_check_test.sv */
`default_nettype none

module take_grant_access_check_test;

    import tgac_pkg::*;

    localparam int NODES    = NODE_COUNT_DEF;
    localparam int NODE_W   = NODE_FIELD_W;
    localparam int RIGHTS_W = RIGHTS_FIELD_W;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Rights that make an edge usable for the reach search
    localparam logic [RIGHTS_W-1:0] TG_MASK     = RIGHTS_W'((1 << TAKE_BIT) | (1 << GRANT_BIT));
    localparam logic [RIGHTS_W-1:0] RIGHTS_KEEP = RIGHTS_W'((1 << RIGHTS_BITS_DEF) - 1);

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_t;

    typedef struct packed {
        logic granted;
        logic holder_found;
    } access_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                req_type = REQ_INSERT;
    logic [NODE_W-1:0]   node_a = '0;
    logic [NODE_W-1:0]   node_b = '0;
    logic [RIGHTS_W-1:0] rights_mask = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic                granted;
    logic                holder_found;

    // Shadow of the protection graph and the last reach set
    logic [RIGHTS_W-1:0] edge_map [NODES][NODES];
    logic [NODES-1:0]    reach_set;

    access_result_t pending_results [$];
    int             mismatch_count = 0;

    // Sender burst / gap control
    int gap_max    = 2;
    int burst_left = 0;

    // Receiver stall control
    stall_style_t stall_style = STALL_LIGHT;
    logic         hold_request = 1'b0;
    int           hold_left = 0;
    int           stall_tick = 0;

    take_grant_access_check u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .node_a       (node_a),
        .node_b       (node_b),
        .rights_mask  (rights_mask),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .holder_found (holder_found)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Graph update: an edge is written in both directions
    function automatic void apply_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                                       input logic [RIGHTS_W-1:0] mask);
        edge_map[a][b] = mask & RIGHTS_KEEP;
        edge_map[b][a] = mask & RIGHTS_KEEP;
    endfunction

    // Possible-access prediction: holders of wanted rights on y, reach from x
    function automatic access_result_t predict_access(input logic [NODE_W-1:0] x,
                                                      input logic [NODE_W-1:0] y,
                                                      input logic [RIGHTS_W-1:0] mask);
        logic [RIGHTS_W-1:0] wanted;
        logic [NODES-1:0]    holders;
        logic [NODES-1:0]    grow;
        logic                changed;
        access_result_t      res;
        wanted  = mask & RIGHTS_KEEP;
        holders = '0;
        for (int h = 0; h < NODES; h++)
        begin
            if (edge_map[h][y] != '0 && (edge_map[h][y] & wanted) == wanted)
                holders[h] = 1'b1;
        end
        reach_set    = '0;
        reach_set[x] = 1'b1;
        do
        begin
            grow = reach_set;
            for (int u = 0; u < NODES; u++)
            begin
                if (reach_set[u])
                begin
                    for (int v = 0; v < NODES; v++)
                    begin
                        if ((edge_map[u][v] & TG_MASK) != '0)
                            grow[v] = 1'b1;
                    end
                end
            end
            changed   = (grow != reach_set);
            reach_set = grow;
        end
        while (changed);
        res.granted      = |(holders & reach_set);
        res.holder_found = |holders;
        return res;
    endfunction

    // Offer one item, honoring bursts and gaps; valid stays high afterwards
    task automatic send_item(input logic kind, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [RIGHTS_W-1:0] mask);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid   <= 1'b1;
        req_type    <= kind;
        node_a      <= a;
        node_b      <= b;
        rights_mask <= mask;
        do
            @(posedge clk);
        while (req_stall);
        // Accepted at this edge
        if (kind == REQ_INSERT)
            apply_edge(a, b, mask);
        else
            pending_results.insert(pending_results.size(), predict_access(a, b, mask));
    endtask

    task automatic idle_sender();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random item: sparse take/grant edges, wanted masks often drawn from live edges
    task automatic send_random_item();
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [RIGHTS_W-1:0] mask;
        logic [NODE_W-1:0]   h;
        int                  pick;
        a    = NODE_W'($urandom_range(0, NODES - 1));
        b    = NODE_W'($urandom_range(0, NODES - 1));
        mask = RIGHTS_W'($urandom);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 40)
        begin
            if (pick < 30)
                mask = '0;
            else if (pick < 50)
                mask = mask | (TG_MASK & RIGHTS_W'($urandom_range(1, 3)));
            else
                mask = mask & ~TG_MASK;
            send_item(REQ_INSERT, a, b, mask);
        end
        else
        begin
            h = NODE_W'($urandom_range(0, NODES - 1));
            if (pick < 20)
                mask = '0;
            else if (pick < 65)
                mask = edge_map[h][b] & RIGHTS_W'($urandom);
            send_item(REQ_QUERY, a, b, mask);
        end
    endtask

    // Receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        stall_tick = stall_tick + 1;
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                STALL_NONE:    rsp_stall <= 1'b0;
                STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 99) < 25);
                STALL_PATTERN: rsp_stall <= ((stall_tick % 7) < 3);
                default:       rsp_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual granted=%b holder_found=%b",
                         $time, granted, holder_found);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (granted !== want.granted)
                begin
                    $display("%0t: granted mismatch, expected %b actual %b",
                             $time, want.granted, granted);
                    mismatch_count++;
                end
                if (holder_found !== want.holder_found)
                begin
                    $display("%0t: holder_found mismatch, expected %b actual %b",
                             $time, want.holder_found, holder_found);
                    mismatch_count++;
                end
            end
        end
    end

    // Field extremes, self edges, edge removal, zero wanted mask
    task automatic test_directed();
        stall_style = STALL_LIGHT;
        gap_max     = 2;
        send_item(REQ_QUERY,  4'd0,  4'd15, 8'h00);   // empty graph
        send_item(REQ_QUERY,  4'd15, 4'd0,  8'hFF);
        send_item(REQ_INSERT, 4'd0,  4'd1,  8'h01);   // take only
        send_item(REQ_INSERT, 4'd1,  4'd2,  8'h02);   // grant only
        send_item(REQ_INSERT, 4'd2,  4'd3,  8'hFF);
        send_item(REQ_QUERY,  4'd0,  4'd3,  8'hFC);   // chain reaches holder
        send_item(REQ_QUERY,  4'd0,  4'd3,  8'h00);   // zero wanted: any edge
        send_item(REQ_QUERY,  4'd15, 4'd3,  8'hFF);   // holder exists, unreachable
        send_item(REQ_INSERT, 4'd5,  4'd5,  8'h80);   // self edge, no take/grant
        send_item(REQ_QUERY,  4'd5,  4'd5,  8'h80);   // x reaches itself
        send_item(REQ_QUERY,  4'd0,  4'd5,  8'h80);
        send_item(REQ_INSERT, 4'd1,  4'd2,  8'h00);   // remove edge
        send_item(REQ_QUERY,  4'd0,  4'd3,  8'hFC);
        send_item(REQ_INSERT, 4'd15, 4'd15, 8'h03);
        send_item(REQ_INSERT, 4'd14, 4'd15, 8'hAA);
        send_item(REQ_INSERT, 4'd1,  4'd14, 8'h55);
        send_item(REQ_QUERY,  4'd0,  4'd15, 8'h03);
        send_item(REQ_QUERY,  4'd0,  4'd15, 8'h0A);
        send_item(REQ_QUERY,  4'd2,  4'd14, 8'h55);   // holder exists, unreachable
        send_item(REQ_QUERY,  4'd14, 4'd1,  8'h54);
        send_item(REQ_INSERT, 4'd3,  4'd2,  8'h7E);   // overwrite from the other side
        send_item(REQ_QUERY,  4'd3,  4'd2,  8'h80);
        send_item(REQ_QUERY,  4'd2,  4'd3,  8'h7E);
    endtask

    // Receiver holds off while the sender keeps offering queries
    task automatic test_long_hold();
        gap_max      = 0;
        hold_request = 1'b1;
        repeat (30)
            send_item(REQ_QUERY, NODE_W'($urandom_range(0, NODES - 1)),
                      NODE_W'($urandom_range(0, NODES - 1)),
                      RIGHTS_W'($urandom_range(0, 3)));
    endtask

    // Sender stops until all results are back, then resumes
    task automatic test_drain_pause();
        gap_max     = 3;
        stall_style = STALL_HEAVY;
        repeat (10)
            send_random_item();
        idle_sender();
        wait_for_results();
        repeat (10)
            send_random_item();
    endtask

    task automatic test_random_traffic();
        for (int r = 0; r < 8; r++)
        begin
            case (r % 4)
                0: stall_style = STALL_LIGHT;
                1: stall_style = STALL_NONE;
                2: stall_style = STALL_PATTERN;
                default: stall_style = STALL_HEAVY;
            endcase
            gap_max = (r % 3 == 1) ? 0 : $urandom_range(1, 8);
            repeat (110)
                send_random_item();
        end
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++)
                edge_map[i][j] = '0;
        reach_set = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_long_hold();
        test_drain_pause();
        test_random_traffic();

        idle_sender();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit
    initial
    begin
        #(20 * CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* take_grant_access_check.f */
rtl/tgac_pkg.sv
rtl/tgac_ram.sv
rtl/tgac_ctrl.sv
rtl/tgac_dp.sv
rtl/take_grant_access_check.sv
tb/sv/take_grant_access_check_test.sv
